/* sv/pbgp_pkg.sv */
// Shared types, constants and clamp helpers for the pixel box ground projection block.
package pbgp_pkg;

  localparam int unsigned PIXEL_BITS_DEF     = 12;
  localparam int unsigned COEF_FRAC_BITS_DEF = 19;
  localparam int unsigned ROW_BITS           = 63;
  localparam int unsigned HEIGHT_BITS        = 15;
  localparam int unsigned OFFSET_BITS        = 16;
  localparam int unsigned LIMIT_LOG2         = 40;
  // projected value range is +/-(2^40 + 2^15)
  localparam int unsigned VAL_BITS           = LIMIT_LOG2 + 2;
  localparam int unsigned DIF_BITS           = VAL_BITS + 1;
  localparam int unsigned CFG_IDX_BITS       = 3;
  localparam int unsigned QUEUE_DEPTH        = 2;

  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 15'd1200;

  localparam logic signed [VAL_BITS-1:0] S32_MAX = VAL_BITS'(64'sh7fffffff);
  localparam logic signed [VAL_BITS-1:0] S32_MIN = VAL_BITS'(-64'sh80000000);
  localparam logic [DIF_BITS-1:0]        U31_MAX = DIF_BITS'(64'h7fffffff);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROW_ZERO,
    REG_ROW_ONE,
    REG_ROW_TWO,
    REG_CAM_HEIGHT,
    REG_LAT_OFFSET,
    REG_LONG_OFFSET
  } cfg_reg_e;

  typedef enum logic {
    MODE_POINT,
    MODE_WIDTH_LENGTH
  } mode_e;

  typedef enum logic [1:0] {
    PT_BOTTOM_MID,
    PT_BOTTOM_LEFT,
    PT_BOTTOM_RIGHT,
    PT_TOP_MID
  } point_e;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_ZERO_DEN,
    FAULT_SATURATED
  } fault_e;

  typedef struct packed {
    mode_e  mode;
    point_e pt;
  } pt_tag_t;

  // side information that rides along the divider pipeline
  typedef struct packed {
    logic    vld;
    pt_tag_t tag;
    logic    neg_x;
    logic    neg_z;
    logic    num_x_neg;
    logic    num_z_neg;
    logic    x_zero;
    logic    z_zero;
    logic    den_zero;
  } div_side_t;

  typedef struct packed {
    logic                       vld;
    pt_tag_t                    tag;
    logic signed [VAL_BITS-1:0] lat;
    logic signed [VAL_BITS-1:0] fwd;
    logic                       zero_den;
    logic                       sat;
  } pt_res_t;

  typedef struct packed {
    logic signed [VAL_BITS-1:0] val;
    logic                       sat;
  } lane_out_t;

  typedef struct packed {
    logic [31:0] val;
    logic        sat;
  } clamp32_t;

  typedef struct packed {
    logic [30:0] val;
    logic        sat;
  } clamp31_t;

  function automatic clamp32_t clamp_s32(input logic signed [VAL_BITS-1:0] v);
    clamp32_t r;
    if (v > S32_MAX) begin
      r.val = 32'h7fffffff;
      r.sat = 1'b1;
    end else if (v < S32_MIN) begin
      r.val = 32'h80000000;
      r.sat = 1'b1;
    end else begin
      r.val = v[31:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic clamp31_t abs_clamp31(input logic signed [DIF_BITS-1:0] d);
    clamp31_t            r;
    logic [DIF_BITS-1:0] m;
    m = d[DIF_BITS-1] ? DIF_BITS'(-d) : d;
    if (m > U31_MAX) begin
      r.val = 31'h7fffffff;
      r.sat = 1'b1;
    end else begin
      r.val = m[30:0];
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

/* sv/pixel_box_to_ground_plane.sv */
// Pixel box to ground plane projection, top level with configuration registers.
//
// Command channel: a box is taken at a clock edge with start_i high and busy_o low.
// busy_o rises only while the two-entry command queue is full.
// Point mode projects the top-left corner; width-length mode projects bottom-middle,
// bottom-left, bottom-right and top-middle points and reports width and length.
// Each point enters one shared projection pipeline per cycle: a point box issues
// one point, a width-length box four; the divider has one stage per quotient bit.
// Results appear on the world_* and fault_o ports with done_o, high for one cycle per result;
// the receiver cannot stall, so the block never holds a result back.
// Configuration: cfg_valid_i/cfg_ready_o write cfg_data_i to register cfg_index_i;
// cfg_ready_o is always high; indexes beyond the list are ignored.
// Reset clears the pipeline and queue and loads register defaults
// (camera height 1200 mm, everything else zero).
module pixel_box_to_ground_plane #(
  parameter int unsigned PIXEL_BITS     = pbgp_pkg::PIXEL_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = pbgp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic                                  op_i,
  input  logic [PIXEL_BITS-1:0]                 box_left_i,
  input  logic [PIXEL_BITS-1:0]                 box_top_i,
  input  logic [PIXEL_BITS-1:0]                 box_width_i,
  input  logic [PIXEL_BITS-1:0]                 box_height_i,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pbgp_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [pbgp_pkg::ROW_BITS-1:0]         cfg_data_i,
  output logic                                  done_o,
  output logic signed [31:0]                    world_lateral_o,
  output logic signed [31:0]                    world_distance_o,
  output logic [30:0]                           world_width_o,
  output logic [30:0]                           world_length_o,
  output logic [1:0]                            fault_o
);

  logic [pbgp_pkg::ROW_BITS-1:0]           row_zero_q, row_one_q, row_two_q;
  logic [pbgp_pkg::HEIGHT_BITS-1:0]        cam_height_q;
  logic signed [pbgp_pkg::OFFSET_BITS-1:0] lat_offset_q, long_offset_q;
  logic                                    cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_zero_q    <= '0;
      row_one_q     <= '0;
      row_two_q     <= '0;
      cam_height_q  <= pbgp_pkg::HEIGHT_RESET;
      lat_offset_q  <= '0;
      long_offset_q <= '0;
    end else if (cfg_we) begin
      case (pbgp_pkg::cfg_reg_e'(cfg_index_i))
        pbgp_pkg::REG_ROW_ZERO:    row_zero_q    <= cfg_data_i;
        pbgp_pkg::REG_ROW_ONE:     row_one_q     <= cfg_data_i;
        pbgp_pkg::REG_ROW_TWO:     row_two_q     <= cfg_data_i;
        pbgp_pkg::REG_CAM_HEIGHT:  cam_height_q  <= cfg_data_i[pbgp_pkg::HEIGHT_BITS-1:0];
        pbgp_pkg::REG_LAT_OFFSET:  lat_offset_q  <= cfg_data_i[pbgp_pkg::OFFSET_BITS-1:0];
        pbgp_pkg::REG_LONG_OFFSET: long_offset_q <= cfg_data_i[pbgp_pkg::OFFSET_BITS-1:0];
        default: begin
          row_zero_q <= row_zero_q;
        end
      endcase
    end
  end

  logic                  q_valid, pop;
  logic [4*PIXEL_BITS:0] q_item;
  pbgp_pkg::pt_res_t     pt_res;

  pbgp_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .op_i         (op_i),
    .box_left_i   (box_left_i),
    .box_top_i    (box_top_i),
    .box_width_i  (box_width_i),
    .box_height_i (box_height_i),
    .pop_i        (pop),
    .q_valid_o    (q_valid),
    .q_item_o     (q_item)
  );

  pbgp_proj #(
    .PIXEL_BITS     (PIXEL_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_proj (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .pop_o         (pop),
    .row_zero_i    (row_zero_q),
    .row_one_i     (row_one_q),
    .row_two_i     (row_two_q),
    .cam_height_i  (cam_height_q),
    .lat_offset_i  (lat_offset_q),
    .long_offset_i (long_offset_q),
    .res_o         (pt_res)
  );

  pbgp_collect u_collect (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .res_i            (pt_res),
    .done_o           (done_o),
    .world_lateral_o  (world_lateral_o),
    .world_distance_o (world_distance_o),
    .world_width_o    (world_width_o),
    .world_length_o   (world_length_o),
    .fault_o          (fault_o)
  );

endmodule

/* sv/pbgp_front.sv */
// Front end: takes box commands and queues them for the projection back end.
module pbgp_front #(
  parameter int unsigned PIXEL_BITS = pbgp_pkg::PIXEL_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic                    op_i,
  input  logic [PIXEL_BITS-1:0]   box_left_i,
  input  logic [PIXEL_BITS-1:0]   box_top_i,
  input  logic [PIXEL_BITS-1:0]   box_width_i,
  input  logic [PIXEL_BITS-1:0]   box_height_i,
  input  logic                    pop_i,
  output logic                    q_valid_o,
  output logic [4*PIXEL_BITS:0]   q_item_o
);

  localparam int unsigned ITEM_W = 4 * PIXEL_BITS + 1;
  localparam int unsigned PTR_W  = $clog2(pbgp_pkg::QUEUE_DEPTH);

  logic [ITEM_W-1:0] mem_q [pbgp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]    cnt_q, cnt_d;
  logic              push, pop;
  pbgp_pkg::mode_e   mode;

  assign busy_o    = (cnt_q == (PTR_W+1)'(pbgp_pkg::QUEUE_DEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign push      = start_i && !busy_o;
  assign pop       = pop_i && q_valid_o;

  // the mode bit decides how many points the back end issues
  assign mode = op_i ? pbgp_pkg::MODE_WIDTH_LENGTH : pbgp_pkg::MODE_POINT;

  always_comb begin
    wr_ptr_d = push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= {mode, box_left_i, box_top_i, box_width_i, box_height_i};
    end
  end

endmodule

/* sv/pbgp_div.sv */
// Pipelined restoring divider, one quotient bit per stage, two numerators over one divisor.
module pbgp_div #(
  parameter int unsigned DEN_BITS = 38,
  parameter int unsigned NUM_BITS = 53
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  pbgp_pkg::div_side_t   side_i,
  input  logic [DEN_BITS-1:0]   den_i,
  input  logic [NUM_BITS-1:0]   num_x_i,
  input  logic [NUM_BITS-1:0]   num_z_i,
  output pbgp_pkg::div_side_t   side_o,
  output logic [DEN_BITS-1:0]   den_o,
  output logic [NUM_BITS-1:0]   quo_x_o,
  output logic [NUM_BITS-1:0]   quo_z_o,
  output logic [DEN_BITS-1:0]   rem_x_o,
  output logic [DEN_BITS-1:0]   rem_z_o
);

  pbgp_pkg::div_side_t side_q [NUM_BITS];
  logic [DEN_BITS-1:0] den_q  [NUM_BITS];
  logic [DEN_BITS-1:0] rem_q  [NUM_BITS][2];
  logic [NUM_BITS-1:0] num_q  [NUM_BITS][2];
  logic [NUM_BITS-1:0] quo_q  [NUM_BITS][2];

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    pbgp_pkg::div_side_t side_in;
    logic [DEN_BITS-1:0] den_in;
    logic [DEN_BITS-1:0] rem_in [2];
    logic [NUM_BITS-1:0] num_in [2];
    logic [NUM_BITS-1:0] quo_in [2];

    if (s == 0) begin : g_first
      assign side_in   = side_i;
      assign den_in    = den_i;
      assign rem_in[0] = '0;
      assign rem_in[1] = '0;
      assign num_in[0] = num_x_i;
      assign num_in[1] = num_z_i;
      assign quo_in[0] = '0;
      assign quo_in[1] = '0;
    end else begin : g_next
      assign side_in   = side_q[s-1];
      assign den_in    = den_q[s-1];
      assign rem_in[0] = rem_q[s-1][0];
      assign rem_in[1] = rem_q[s-1][1];
      assign num_in[0] = num_q[s-1][0];
      assign num_in[1] = num_q[s-1][1];
      assign quo_in[0] = quo_q[s-1][0];
      assign quo_in[1] = quo_q[s-1][1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [DEN_BITS:0]   trial;
      logic [DEN_BITS:0]   diff;
      logic                ge;
      logic [DEN_BITS-1:0] rem_d;

      // remainder stays below the divisor, so both outcomes fit DEN_BITS
      assign trial = {rem_in[l], num_in[l][NUM_BITS-1]};
      assign diff  = trial - {1'b0, den_in};
      assign ge    = (trial >= {1'b0, den_in});
      assign rem_d = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

      always_ff @(posedge clk_i) begin
        rem_q[s][l] <= rem_d;
        num_q[s][l] <= num_in[l] << 1;
        quo_q[s][l] <= {quo_in[l][NUM_BITS-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[s] <= '0;
      end else begin
        side_q[s] <= side_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
    end
  end

  assign side_o  = side_q[NUM_BITS-1];
  assign den_o   = den_q[NUM_BITS-1];
  assign quo_x_o = quo_q[NUM_BITS-1][0];
  assign quo_z_o = quo_q[NUM_BITS-1][1];
  assign rem_x_o = rem_q[NUM_BITS-1][0];
  assign rem_z_o = rem_q[NUM_BITS-1][1];

endmodule

/* sv/pbgp_proj.sv */
// Back end: issues box points and projects each onto the ground plane in a pipeline.
module pbgp_proj #(
  parameter int unsigned PIXEL_BITS     = pbgp_pkg::PIXEL_BITS_DEF,
  parameter int unsigned COEF_FRAC_BITS = pbgp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    q_valid_i,
  input  logic [4*PIXEL_BITS:0]                   q_item_i,
  output logic                                    pop_o,
  input  logic [pbgp_pkg::ROW_BITS-1:0]           row_zero_i,
  input  logic [pbgp_pkg::ROW_BITS-1:0]           row_one_i,
  input  logic [pbgp_pkg::ROW_BITS-1:0]           row_two_i,
  input  logic [pbgp_pkg::HEIGHT_BITS-1:0]        cam_height_i,
  input  logic signed [pbgp_pkg::OFFSET_BITS-1:0] lat_offset_i,
  input  logic signed [pbgp_pkg::OFFSET_BITS-1:0] long_offset_i,
  output pbgp_pkg::pt_res_t                       res_o
);

  localparam int unsigned CB   = COEF_FRAC_BITS + 2;
  localparam int unsigned UB   = PIXEL_BITS + 2;
  localparam int unsigned PROD = CB + UB + 1;
  localparam int unsigned DOT  = PROD + 2;
  localparam int unsigned NB   = pbgp_pkg::HEIGHT_BITS + DOT;
  localparam int unsigned XW   = 3 * CB + pbgp_pkg::ROW_BITS;
  localparam int unsigned VB   = pbgp_pkg::VAL_BITS;
  localparam int unsigned LB   = pbgp_pkg::LIMIT_LOG2;

  // ---------------- point sequencer ----------------
  logic                  act_q, act_d;
  pbgp_pkg::point_e      cnt_q, cnt_d;
  pbgp_pkg::mode_e       mode_q, mode_d;
  logic [PIXEL_BITS-1:0] left_q, top_q, wid_q, hgt_q;
  logic                  last_pt;
  logic                  pop;

  assign last_pt = (mode_q == pbgp_pkg::MODE_POINT) || (cnt_q == pbgp_pkg::PT_TOP_MID);
  assign pop     = q_valid_i && (!act_q || last_pt);
  assign pop_o   = pop;

  always_comb begin
    act_d  = act_q;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    if (pop) begin
      act_d  = 1'b1;
      cnt_d  = pbgp_pkg::PT_BOTTOM_MID;
      mode_d = pbgp_pkg::mode_e'(q_item_i[4*PIXEL_BITS]);
    end else if (act_q && last_pt) begin
      act_d = 1'b0;
    end else if (act_q) begin
      cnt_d = pbgp_pkg::point_e'(cnt_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      cnt_q  <= pbgp_pkg::PT_BOTTOM_MID;
      mode_q <= pbgp_pkg::MODE_POINT;
    end else begin
      act_q  <= act_d;
      cnt_q  <= cnt_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      left_q <= q_item_i[4*PIXEL_BITS-1 -: PIXEL_BITS];
      top_q  <= q_item_i[3*PIXEL_BITS-1 -: PIXEL_BITS];
      wid_q  <= q_item_i[2*PIXEL_BITS-1 -: PIXEL_BITS];
      hgt_q  <= q_item_i[PIXEL_BITS-1:0];
    end
  end

  // half-pixel coordinates of the point being issued
  logic [UB-1:0] i2, j2, w1, bottom, u_d, v_d;

  assign i2     = UB'({left_q, 1'b0});
  assign j2     = UB'({top_q, 1'b0});
  assign w1     = UB'(wid_q);
  assign bottom = j2 + UB'({hgt_q, 1'b0});

  always_comb begin
    u_d = i2 + w1;
    v_d = bottom;
    case (cnt_q)
      pbgp_pkg::PT_BOTTOM_MID: begin
        if (mode_q == pbgp_pkg::MODE_POINT) begin
          u_d = i2;
          v_d = j2;
        end
      end
      pbgp_pkg::PT_BOTTOM_LEFT:  u_d = i2;
      pbgp_pkg::PT_BOTTOM_RIGHT: u_d = i2 + (w1 << 1);
      pbgp_pkg::PT_TOP_MID:      v_d = j2;
      default:                   u_d = i2 + w1;
    endcase
  end

  logic              s0_vld_q;
  pbgp_pkg::pt_tag_t s0_tag_q;
  logic [UB-1:0]     u_q, v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_tag_q <= '{mode: mode_q, pt: cnt_q};
    u_q      <= u_d;
    v_q      <= v_d;
  end

  // ---------------- coefficient products ----------------
  logic [pbgp_pkg::ROW_BITS-1:0] rows [3];
  logic signed [CB-1:0]          coef [3][3];

  assign rows[0] = row_zero_i;
  assign rows[1] = row_one_i;
  assign rows[2] = row_two_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        coef[r][k] = $signed(CB'(XW'(rows[r]) >> (k * CB)));
      end
    end
  end

  logic                   s1_vld_q;
  pbgp_pkg::pt_tag_t      s1_tag_q;
  logic signed [PROD-1:0] p_q  [3][2];
  logic signed [CB-1:0]   c2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= s0_tag_q;
    for (int r = 0; r < 3; r++) begin
      p_q[r][0] <= coef[r][0] * $signed({1'b0, u_q});
      p_q[r][1] <= coef[r][1] * $signed({1'b0, v_q});
      c2_q[r]   <= coef[r][2];
    end
  end

  // ---------------- ray components ----------------
  logic                  s2_vld_q;
  pbgp_pkg::pt_tag_t     s2_tag_q;
  logic signed [DOT-1:0] dot_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_tag_q <= s1_tag_q;
    for (int r = 0; r < 3; r++) begin
      dot_q[r] <= DOT'(p_q[r][0]) + DOT'(p_q[r][1]) + (DOT'(c2_q[r]) <<< 1);
    end
  end

  // ---------------- height scaling, divider operands ----------------
  logic [DOT-1:0]      mag_x, mag_y, mag_z;
  pbgp_pkg::div_side_t s3_side_d, s3_side_q;
  logic [DOT-1:0]      den_q;
  logic [NB-1:0]       num_x_q, num_z_q;

  assign mag_x = dot_q[0][DOT-1] ? DOT'(-dot_q[0]) : DOT'(dot_q[0]);
  assign mag_y = dot_q[1][DOT-1] ? DOT'(-dot_q[1]) : DOT'(dot_q[1]);
  assign mag_z = dot_q[2][DOT-1] ? DOT'(-dot_q[2]) : DOT'(dot_q[2]);

  always_comb begin
    s3_side_d.vld       = s2_vld_q;
    s3_side_d.tag       = s2_tag_q;
    s3_side_d.neg_x     = dot_q[0][DOT-1] ^ dot_q[1][DOT-1];
    s3_side_d.neg_z     = dot_q[2][DOT-1] ^ dot_q[1][DOT-1];
    s3_side_d.num_x_neg = dot_q[0][DOT-1];
    s3_side_d.num_z_neg = dot_q[2][DOT-1];
    s3_side_d.x_zero    = (mag_x == '0);
    s3_side_d.z_zero    = (mag_z == '0);
    s3_side_d.den_zero  = (mag_y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_side_q <= '0;
    end else begin
      s3_side_q <= s3_side_d;
    end
  end

  always_ff @(posedge clk_i) begin
    den_q   <= mag_y;
    num_x_q <= NB'(cam_height_i) * NB'(mag_x);
    num_z_q <= NB'(cam_height_i) * NB'(mag_z);
  end

  // ---------------- divider ----------------
  pbgp_pkg::div_side_t dv_side;
  logic [DOT-1:0]      dv_den, dv_rem_x, dv_rem_z;
  logic [NB-1:0]       dv_quo_x, dv_quo_z;

  pbgp_div #(
    .DEN_BITS (DOT),
    .NUM_BITS (NB)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .side_i  (s3_side_q),
    .den_i   (den_q),
    .num_x_i (num_x_q),
    .num_z_i (num_z_q),
    .side_o  (dv_side),
    .den_o   (dv_den),
    .quo_x_o (dv_quo_x),
    .quo_z_o (dv_quo_z),
    .rem_x_o (dv_rem_x),
    .rem_z_o (dv_rem_z)
  );

  // ---------------- rounding and saturation ----------------
  logic h_zero, h_one;

  assign h_zero = (cam_height_i == '0);
  assign h_one  = (cam_height_i == pbgp_pkg::HEIGHT_BITS'(1));

  function automatic pbgp_pkg::lane_out_t finish_lane(
    input logic [NB-1:0]  quo,
    input logic [DOT-1:0] rem,
    input logic [DOT-1:0] den,
    input logic           neg,
    input logic           num_neg,
    input logic           num_zero,
    input logic           den_zero,
    input logic           hz,
    input logic           ho
  );
    pbgp_pkg::lane_out_t r;
    logic [NB:0]         lim;
    logic [NB:0]         tot;
    logic                rnd;
    logic                sgn;
    logic [LB:0]         mag;
    lim   = (NB+1)'(1) << LB;
    rnd   = ({rem, 1'b0} >= {1'b0, den});
    tot   = {1'b0, quo} + (NB+1)'(rnd);
    r.sat = 1'b0;
    sgn   = neg;
    if (den_zero) begin
      sgn = num_neg;
      mag = (num_zero || hz) ? '0 : lim[LB:0];
    end else if ((tot > lim) || (ho && ({1'b0, quo} >= lim))) begin
      // with camera height 1, a whole quotient of 2^40 or more saturates even when the rounded total is not above 2^40
      mag   = lim[LB:0];
      r.sat = 1'b1;
    end else begin
      mag = tot[LB:0];
    end
    r.val = sgn ? -$signed(VB'(mag)) : $signed(VB'(mag));
    return r;
  endfunction

  pbgp_pkg::lane_out_t lane_x, lane_z;

  assign lane_x = finish_lane(dv_quo_x, dv_rem_x, dv_den, dv_side.neg_x, dv_side.num_x_neg,
                              dv_side.x_zero, dv_side.den_zero, h_zero, h_one);
  assign lane_z = finish_lane(dv_quo_z, dv_rem_z, dv_den, dv_side.neg_z, dv_side.num_z_neg,
                              dv_side.z_zero, dv_side.den_zero, h_zero, h_one);

  logic                 f1_vld_q;
  pbgp_pkg::pt_tag_t    f1_tag_q;
  logic signed [VB-1:0] qx_q, qz_q;
  logic                 f1_zero_q, f1_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
    end else begin
      f1_vld_q <= dv_side.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_tag_q  <= dv_side.tag;
    qx_q      <= lane_x.val;
    qz_q      <= lane_z.val;
    f1_zero_q <= dv_side.den_zero;
    f1_sat_q  <= lane_x.sat | lane_z.sat;
  end

  // ---------------- camera offsets ----------------
  pbgp_pkg::pt_res_t res_d, res_q;

  always_comb begin
    res_d.vld      = f1_vld_q;
    res_d.tag      = f1_tag_q;
    res_d.lat      = qx_q - VB'(lat_offset_i);
    res_d.fwd      = qz_q + VB'(long_offset_i);
    res_d.zero_den = f1_zero_q;
    res_d.sat      = f1_sat_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

/* sv/pbgp_collect.sv */
// Back end tail: combines the projected points of one box into a result.
module pbgp_collect (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbgp_pkg::pt_res_t res_i,
  output logic              done_o,
  output logic [31:0]       world_lateral_o,
  output logic [31:0]       world_distance_o,
  output logic [30:0]       world_width_o,
  output logic [30:0]       world_length_o,
  output logic [1:0]        fault_o
);

  localparam int unsigned VB = pbgp_pkg::VAL_BITS;
  localparam int unsigned DB = pbgp_pkg::DIF_BITS;

  logic signed [VB-1:0] bm_lat_q, bm_lat_d;
  logic signed [VB-1:0] bm_dist_q, bm_dist_d;
  logic signed [VB-1:0] l_lat_q, l_lat_d;
  logic [30:0]          wid_q, wid_d;
  logic                 accz_q, accz_d;
  logic                 accs_q, accs_d;

  logic                 done_q, done_d;
  logic [31:0]          lat_q, lat_d, dist_q, dist_d;
  logic [30:0]          width_q, width_d, len_q, len_d;
  pbgp_pkg::fault_e     fault_q, fault_d;

  logic                 first, last, wl;
  logic                 zf, sf;
  logic signed [VB-1:0] out_lat, out_dist;
  pbgp_pkg::clamp31_t   wclamp, lclamp;
  pbgp_pkg::clamp32_t   lat_c, dist_c;

  assign first = (res_i.tag.pt == pbgp_pkg::PT_BOTTOM_MID);
  assign wl    = (res_i.tag.mode == pbgp_pkg::MODE_WIDTH_LENGTH);
  assign last  = !wl || (res_i.tag.pt == pbgp_pkg::PT_TOP_MID);

  assign wclamp   = pbgp_pkg::abs_clamp31(DB'(l_lat_q) - DB'(res_i.lat));
  assign lclamp   = pbgp_pkg::abs_clamp31(DB'(res_i.fwd) - DB'(bm_dist_q));
  assign out_lat  = wl ? bm_lat_q : res_i.lat;
  assign out_dist = wl ? bm_dist_q : res_i.fwd;
  assign lat_c    = pbgp_pkg::clamp_s32(out_lat);
  assign dist_c   = pbgp_pkg::clamp_s32(out_dist);

  always_comb begin
    bm_lat_d  = bm_lat_q;
    bm_dist_d = bm_dist_q;
    l_lat_d   = l_lat_q;
    wid_d     = wid_q;
    zf        = (first ? 1'b0 : accz_q) | res_i.zero_den;
    sf        = (first ? 1'b0 : accs_q) | res_i.sat;
    case (res_i.tag.pt)
      pbgp_pkg::PT_BOTTOM_MID: begin
        bm_lat_d  = res_i.lat;
        bm_dist_d = res_i.fwd;
      end
      pbgp_pkg::PT_BOTTOM_LEFT: begin
        l_lat_d = res_i.lat;
      end
      pbgp_pkg::PT_BOTTOM_RIGHT: begin
        wid_d = wclamp.val;
        sf    = sf | wclamp.sat;
      end
      pbgp_pkg::PT_TOP_MID: begin
        sf = sf | lclamp.sat;
      end
      default: begin
        wid_d = wid_q;
      end
    endcase

    accz_d = res_i.vld ? zf : accz_q;
    accs_d = res_i.vld ? sf : accs_q;

    done_d  = res_i.vld && last;
    lat_d   = lat_c.val;
    dist_d  = dist_c.val;
    width_d = wl ? wid_q : '0;
    len_d   = wl ? lclamp.val : '0;
    if (zf) begin
      fault_d = pbgp_pkg::FAULT_ZERO_DEN;
    end else if (sf || lat_c.sat || dist_c.sat) begin
      fault_d = pbgp_pkg::FAULT_SATURATED;
    end else begin
      fault_d = pbgp_pkg::FAULT_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      accz_q <= 1'b0;
      accs_q <= 1'b0;
    end else begin
      done_q <= done_d;
      accz_q <= accz_d;
      accs_q <= accs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.vld) begin
      bm_lat_q  <= bm_lat_d;
      bm_dist_q <= bm_dist_d;
      l_lat_q   <= l_lat_d;
      wid_q     <= wid_d;
    end
    if (done_d) begin
      lat_q   <= lat_d;
      dist_q  <= dist_d;
      width_q <= width_d;
      len_q   <= len_d;
      fault_q <= fault_d;
    end
  end

  assign done_o           = done_q;
  assign world_lateral_o  = lat_q;
  assign world_distance_o = dist_q;
  assign world_width_o    = width_q;
  assign world_length_o   = len_q;
  assign fault_o          = fault_q;

endmodule

/* sv/pbgp_checker.sv */
// Port-level checks for the pixel box ground projection block, bound to the top level.
module pbgp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic [1:0] fault_o
);

  // only the three defined fault codes come out with a result
  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fault_o == pbgp_pkg::FAULT_NONE || fault_o == pbgp_pkg::FAULT_ZERO_DEN ||
                fault_o == pbgp_pkg::FAULT_SATURATED))
    else $error("undefined fault code on result");

  // the queue only fills through accepted transactions
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a transaction");

  // right after reset nothing is in flight
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> (!done_o && !busy_o))
    else $error("result or busy right after reset");

endmodule

bind pixel_box_to_ground_plane pbgp_checker u_pbgp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .fault_o (fault_o)
);

/* verif/tb.sv */
// Self-checking testbench for the pixel box to ground plane projection block.
`timescale 1ns / 1ps

class ground_plane_scoreboard;
  localparam int COEF_BITS = pbgp_pkg::COEF_FRAC_BITS_DEF + 2;
  localparam longint QUOT_LIMIT = 64'sd1 << 40;
  localparam int F_ZERO = 1;
  localparam int F_SAT = 2;

  typedef struct {
    logic [31:0] lateral;
    logic [31:0] distance;
    logic [30:0] width;
    logic [30:0] length;
    pbgp_pkg::fault_e fault;
  } ground_point_t;

  logic [62:0] rows[3];
  logic [14:0] cam_height;
  logic signed [15:0] lat_off;
  logic signed [15:0] long_off;
  ground_point_t expected_q[$];
  int errors;

  function new();
    rows[0] = '0; rows[1] = '0; rows[2] = '0;
    cam_height = pbgp_pkg::HEIGHT_RESET;
    lat_off = '0;
    long_off = '0;
    errors = 0;
  endfunction

  function void write_reg(pbgp_pkg::cfg_reg_e idx, logic [62:0] data);
    case (idx)
      pbgp_pkg::REG_ROW_ZERO: rows[0] = data;
      pbgp_pkg::REG_ROW_ONE: rows[1] = data;
      pbgp_pkg::REG_ROW_TWO: rows[2] = data;
      pbgp_pkg::REG_CAM_HEIGHT: cam_height = data[14:0];
      pbgp_pkg::REG_LAT_OFFSET: lat_off = data[15:0];
      pbgp_pkg::REG_LONG_OFFSET: long_off = data[15:0];
      default: ;
    endcase
  endfunction

  function longint coef(int r, int k);
    logic signed [COEF_BITS-1:0] c;
    c = COEF_BITS'(rows[r] >> (k * COEF_BITS));
    return longint'(c);
  endfunction

  function longint ray(int r, longint u2, longint v2);
    return coef(r, 0) * u2 + coef(r, 1) * v2 + 2 * coef(r, 2);
  endfunction

  // round(h * num / den), ties away from zero, saturated to +/-2^40
  function longint height_ratio(longint num, longint den, inout int flags);
    longint unsigned a, b, q1, r1, q, rem, tot, h;
    bit neg;
    h = cam_height;
    neg = (num < 0) != (den < 0);
    a = num < 0 ? -num : num;
    b = den < 0 ? -den : den;
    if (b == 0) begin
      flags |= F_ZERO;
      if (a == 0 || h == 0) return 0;
      return num < 0 ? -QUOT_LIMIT : QUOT_LIMIT;
    end
    if (h == 0 || a == 0) return 0;
    q1 = a / b;
    r1 = a % b;
    if (q1 >= QUOT_LIMIT) begin
      flags |= F_SAT;
      return neg ? -QUOT_LIMIT : QUOT_LIMIT;
    end
    q = 0;
    rem = 0;
    for (int bt = 14; bt >= 0; bt--) begin
      q = q << 1;
      rem = rem << 1;
      if (rem >= b) begin rem -= b; q++; end
      if (h[bt]) begin
        rem += r1;
        if (rem >= b) begin rem -= b; q++; end
      end
    end
    tot = h * q1 + q;
    if (2 * rem >= b) tot++;
    if (tot > QUOT_LIMIT) begin
      flags |= F_SAT;
      tot = QUOT_LIMIT;
    end
    return neg ? -longint'(tot) : longint'(tot);
  endfunction

  function void project(longint u2, longint v2, output longint lat, output longint fwd,
                        inout int flags);
    longint x, y, z;
    x = ray(0, u2, v2);
    y = ray(1, u2, v2);
    z = ray(2, u2, v2);
    lat = height_ratio(x, y, flags) - longint'(lat_off);
    fwd = height_ratio(z, y, flags) + longint'(long_off);
  endfunction

  function logic [31:0] clamp32(longint v, inout int flags);
    if (v > 64'sh7fffffff) begin v = 64'sh7fffffff; flags |= F_SAT; end
    if (v < -64'sh80000000) begin v = -64'sh80000000; flags |= F_SAT; end
    return v[31:0];
  endfunction

  function logic [30:0] abs31(longint a, longint b, inout int flags);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    if (d > 64'sh7fffffff) begin d = 64'sh7fffffff; flags |= F_SAT; end
    return d[30:0];
  endfunction

  // note an accepted box and queue its expected ground position
  function void note_box(pbgp_pkg::mode_e mode, logic [11:0] left, logic [11:0] top,
                         logic [11:0] w, logic [11:0] hgt);
    ground_point_t e;
    longint i2, j2, bot, lat, fwd, l_lat, l_dist, r_lat, r_dist, t_lat, t_dist;
    int flags;
    flags = 0;
    i2 = 2 * longint'(left);
    j2 = 2 * longint'(top);
    e.width = '0;
    e.length = '0;
    if (mode == pbgp_pkg::MODE_POINT) begin
      project(i2, j2, lat, fwd, flags);
    end else begin
      bot = j2 + 2 * longint'(hgt);
      project(i2 + longint'(w), bot, lat, fwd, flags);
      project(i2, bot, l_lat, l_dist, flags);
      project(i2 + 2 * longint'(w), bot, r_lat, r_dist, flags);
      project(i2 + longint'(w), j2, t_lat, t_dist, flags);
      e.width = abs31(l_lat, r_lat, flags);
      e.length = abs31(t_dist, fwd, flags);
    end
    e.lateral = clamp32(lat, flags);
    e.distance = clamp32(fwd, flags);
    e.fault = (flags & F_ZERO) ? pbgp_pkg::FAULT_ZERO_DEN :
              (flags & F_SAT) ? pbgp_pkg::FAULT_SATURATED : pbgp_pkg::FAULT_NONE;
    expected_q = {expected_q, e};
  endfunction

  function void check_result(logic [31:0] lat, logic [31:0] fwd, logic [30:0] w,
                             logic [30:0] len, logic [1:0] fault);
    ground_point_t e;
    if (expected_q.size() == 0) begin
      $error("unexpected result: lateral %0d distance %0d", $signed(lat), $signed(fwd));
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (lat !== e.lateral) begin
      $error("world_lateral: expected %0d, got %0d", $signed(e.lateral), $signed(lat));
      errors++;
    end
    if (fwd !== e.distance) begin
      $error("world_distance: expected %0d, got %0d", $signed(e.distance), $signed(fwd));
      errors++;
    end
    if (w !== e.width) begin
      $error("world_width: expected %0d, got %0d", e.width, w);
      errors++;
    end
    if (len !== e.length) begin
      $error("world_length: expected %0d, got %0d", e.length, len);
      errors++;
    end
    if (fault !== e.fault) begin
      $error("fault: expected %0d, got %0d", e.fault, fault);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic op_i = 1'b0;
  logic [11:0] box_left_i = '0;
  logic [11:0] box_top_i = '0;
  logic [11:0] box_width_i = '0;
  logic [11:0] box_height_i = '0;
  logic cfg_valid_i = 1'b0;
  logic [pbgp_pkg::CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [pbgp_pkg::ROW_BITS-1:0] cfg_data_i = '0;
  logic busy_o, cfg_ready_o, done_o;
  logic signed [31:0] world_lateral_o, world_distance_o;
  logic [30:0] world_width_o, world_length_o;
  logic [1:0] fault_o;

  ground_plane_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  always #2 clk_i = ~clk_i;

  pixel_box_to_ground_plane DUT (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        sb.check_result(world_lateral_o, world_distance_o, world_width_o, world_length_o,
                        fault_o);
      if ((start_i && !busy_o) || done_o || cfg_valid_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_cfg(pbgp_pkg::cfg_reg_e idx, logic [62:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
  endtask

  function automatic logic [20:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 21'h100000;
      1: return 21'h0fffff;
      2: return '0;
      3: return 21'($signed($urandom_range(0, 64)) - 32);
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] pack_row(logic [20:0] c0, logic [20:0] c1, logic [20:0] c2);
    return {c2, c1, c0};
  endfunction

  // full register set; settings made between batches with the block drained
  task automatic load_setup(logic [62:0] r0, logic [62:0] r1, logic [62:0] r2,
                            logic [14:0] hgt, logic [15:0] lo, logic [15:0] go);
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    write_cfg(pbgp_pkg::REG_ROW_ZERO, r0);
    write_cfg(pbgp_pkg::REG_ROW_ONE, r1);
    write_cfg(pbgp_pkg::REG_ROW_TWO, r2);
    write_cfg(pbgp_pkg::REG_CAM_HEIGHT, {48'($urandom), hgt});
    write_cfg(pbgp_pkg::REG_LAT_OFFSET, {47'($urandom), lo});
    write_cfg(pbgp_pkg::REG_LONG_OFFSET, {47'($urandom), go});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_box(pbgp_pkg::mode_e mode, logic [11:0] left, logic [11:0] top,
                          logic [11:0] w, logic [11:0] hgt);
    start_i <= 1'b1;
    op_i <= mode;
    box_left_i <= left;
    box_top_i <= top;
    box_width_i <= w;
    box_height_i <= hgt;
    do @(posedge clk_i); while (busy_o);
    sb.note_box(mode, left, top, w, hgt);
    if (!no_gaps && $urandom_range(0, 99) < 13) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic logic [11:0] rand_pix();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 12'hfff;
      2: return 12'($urandom_range(0, 15));
      default: return 12'($urandom);
    endcase
  endfunction

  task automatic random_batch(int count);
    for (int n = 0; n < count; n++)
      send_box(pbgp_pkg::mode_e'($urandom_range(0, 1)), rand_pix(), rand_pix(), rand_pix(),
               rand_pix());
  endtask

  // plausible camera: x ~ u - cu, y ~ v - horizon, z ~ focal
  task automatic realistic_setup(int horizon);
    logic [20:0] one;
    one = 21'(1 << 12);
    load_setup(pack_row(one, '0, 21'(-(640 << 12))),
               pack_row('0, one, 21'(-(horizon << 12))),
               pack_row('0, '0, 21'(1000 << 12)),
               15'($urandom_range(500, 3000)), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all-zero matrix gives zero denominators
    send_box(pbgp_pkg::MODE_POINT, 12'd100, 12'd200, 12'd10, 12'd10);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd100, 12'd200, 12'd10, 12'd10);

    realistic_setup(360);
    send_box(pbgp_pkg::MODE_POINT, 12'd640, 12'd500, 12'd0, 12'd0);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd600, 12'd400, 12'd80, 12'd60);
    send_box(pbgp_pkg::MODE_POINT, 12'd640, 12'd360, 12'd0, 12'd0);          // on the horizon
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd600, 12'd300, 12'd80, 12'd30); // box above the horizon
    send_box(pbgp_pkg::MODE_POINT, 12'd0, 12'd361, 12'd0, 12'd0);            // near horizon
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_box(pbgp_pkg::MODE_POINT, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd0, 12'd0, 12'd0, 12'd0);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd0, 12'd359, 12'd4000, 12'd1);
    send_box(pbgp_pkg::MODE_POINT, 12'd0, 12'd0, 12'd0, 12'd0);

    // extreme coefficients and offsets, tiny denominators to force saturation
    load_setup(pack_row(21'h0fffff, 21'h0fffff, 21'h0fffff), pack_row('0, '0, 21'd1),
               pack_row(21'h100000, 21'h100000, 21'h100000), 15'h7fff, 16'h8000, 16'h7fff);
    send_box(pbgp_pkg::MODE_POINT, 12'hfff, 12'hfff, 12'd0, 12'd0);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'd0, 12'd0, 12'd1, 12'd1);

    load_setup(pack_row(21'h100000, '0, '0), pack_row(21'h0fffff, 21'h0fffff, 21'h0fffff),
               pack_row('0, 21'h100000, '0), 15'd0, 16'h7fff, 16'h8000);
    send_box(pbgp_pkg::MODE_POINT, 12'd5, 12'd7, 12'd0, 12'd0);
    send_box(pbgp_pkg::MODE_WIDTH_LENGTH, 12'hfff, 12'd0, 12'hfff, 12'd0);

    // mostly geometry that makes sense, then noisy matrices
    for (int p = 0; p < 8; p++) begin
      realistic_setup($urandom_range(0, 4095));
      no_gaps = (p == 3);
      random_batch(110);
    end
    no_gaps = 1'b0;
    for (int p = 0; p < 5; p++) begin
      load_setup(pack_row(rand_coef(), rand_coef(), rand_coef()),
                 pack_row(rand_coef(), rand_coef(), rand_coef()),
                 pack_row(rand_coef(), rand_coef(), rand_coef()),
                 p == 0 ? 15'h7fff : 15'($urandom), p == 1 ? 16'h8000 : 16'($urandom),
                 p == 2 ? 16'h8000 : 16'($urandom));
      random_batch(110);
    end

    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

/* pixel_box_to_ground_plane.f */
sv/pbgp_pkg.sv
sv/pbgp_front.sv
sv/pbgp_div.sv
sv/pbgp_proj.sv
sv/pbgp_collect.sv
sv/pixel_box_to_ground_plane.sv
sv/pbgp_checker.sv
verif/tb.sv
